### rtl/rieu_pkg.sv
`default_nettype none
package rieu_pkg;
  localparam int unsigned XLEN = 32;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [31:0] EXIT_CODE = 32'h0000_000A;

  typedef enum logic [1:0] {
    LONG_NONE = 2'd0,
    LONG_MUL  = 2'd1,
    LONG_DIV  = 2'd2
  } long_e;

  typedef struct packed {
    logic  load;
    long_e long_op;
    logic  start;
    logic  step;
    logic  finish;
  } ctl_t;

  typedef struct packed {
    logic  last;
    long_e long_op;
  } sts_t;
endpackage
`default_nettype wire

### rtl/rieu_ctrl.sv
`default_nettype none
module rieu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rieu_pkg::sts_t sts_i,
  output rieu_pkg::ctl_t     ctl_o
);
  import rieu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    ctl_o         = '0;
    ctl_o.long_op = sts_i.long_op;
    ctl_o.load    = accept;
    case (state_q)
      S_IDLE, S_OUT: begin
        if (accept) begin
          state_d = S_PREP;
        end else if (state_q == S_OUT && out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_PREP: begin
        if (sts_i.long_op == LONG_NONE) begin
          ctl_o.finish = 1'b1;
          state_d      = S_OUT;
        end else begin
          ctl_o.start = 1'b1;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.last) begin
          ctl_o.finish = 1'b1;
          state_d      = S_OUT;
        end else begin
          ctl_o.step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

### rtl/rieu_dpath.sv
`default_nettype none
module rieu_dpath #(
  parameter int unsigned Xlen = rieu_pkg::XLEN
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rieu_pkg::ctl_t   ctl_i,
  output rieu_pkg::sts_t        sts_o,
  input  wire logic [5:0]       mode_i,
  input  wire logic [5:0]       function_code_i,
  input  wire logic [Xlen-1:0]  operand_a_i,
  input  wire logic [Xlen-1:0]  operand_b_i,
  input  wire logic [15:0]      immediate_i,
  input  wire logic [4:0]       shift_amount_i,
  input  wire logic [Xlen-1:0]  syscall_code_i,
  output logic [Xlen-1:0]       result_o,
  output logic                  result_valid_o,
  output logic [Xlen-1:0]       hi_value_o,
  output logic [Xlen-1:0]       lo_value_o,
  output logic                  halt_o,
  output logic                  unsupported_o
);
  import rieu_pkg::*;

  localparam int unsigned CntW = $clog2(Xlen) + 1;

  logic [5:0]      op_q, fn_q;
  logic [Xlen-1:0] a_q, b_q, code_q;
  logic [15:0]     imm_q;
  logic [4:0]      sa_q;
  logic [Xlen-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [Xlen-1:0] res_q, res_d;
  logic            vld_q, vld_d, halt_q, halt_d, uns_q, uns_d;

  // shared shift-add / restoring-divide engine on magnitudes
  logic [Xlen-1:0] acc_q, acc_d, mq_q, mq_d, dv_q, dv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q_q, neg_r_q, neg_q_d, neg_r_d;

  logic [Xlen-1:0] sext_imm, zext_imm, add_imm, prod_b;
  logic [Xlen:0]   madd, rem_try;
  logic [Xlen-1:0] rem_sh;
  logic [2*Xlen-1:0] prod_full, prod_neg;
  logic            na, nb, div0;
  long_e           kind;
  logic            sgn;

  assign sext_imm = {{(Xlen-16){imm_q[15]}}, imm_q};
  assign zext_imm = {{(Xlen-16){1'b0}}, imm_q};
  assign add_imm  = a_q + sext_imm;
  assign na       = a_q[Xlen-1];
  assign nb       = b_q[Xlen-1];
  assign div0     = (b_q == '0);

  always_comb begin
    kind = LONG_NONE;
    if (op_q == OP_SPECIAL) begin
      if (fn_q == FN_MULT || fn_q == FN_MULTU) begin
        kind = LONG_MUL;
      end else if ((fn_q == FN_DIV || fn_q == FN_DIVU) && !div0) begin
        kind = LONG_DIV;
      end
    end
  end
  assign sts_o.long_op = kind;
  assign sts_o.last    = (cnt_q == CntW'(Xlen));

  assign sgn = (fn_q == FN_MULT) || (fn_q == FN_DIV);

  // iteration datapath
  assign prod_b  = mq_q[0] ? dv_q : '0;
  assign madd    = {1'b0, acc_q} + {1'b0, prod_b};
  assign rem_sh  = {acc_q[Xlen-2:0], mq_q[Xlen-1]};
  assign rem_try = {acc_q[Xlen-1], rem_sh} - {1'b0, dv_q};
  assign prod_full = {acc_q, mq_q};
  assign prod_neg  = '0 - prod_full;

  always_comb begin
    acc_d   = acc_q;
    mq_d    = mq_q;
    dv_d    = dv_q;
    cnt_d   = cnt_q;
    neg_q_d = neg_q_q;
    neg_r_d = neg_r_q;
    if (ctl_i.start) begin
      acc_d   = '0;
      cnt_d   = '0;
      mq_d    = (sgn && na) ? ('0 - a_q) : a_q;
      dv_d    = (sgn && nb) ? ('0 - b_q) : b_q;
      neg_q_d = sgn && (na != nb);
      neg_r_d = sgn && na;
    end else if (ctl_i.step) begin
      cnt_d = cnt_q + CntW'(1);
      if (ctl_i.long_op == LONG_MUL) begin
        acc_d = madd[Xlen:1];
        mq_d  = {madd[0], mq_q[Xlen-1:1]};
      end else begin
        if (!rem_try[Xlen]) begin
          acc_d = rem_try[Xlen-1:0];
          mq_d  = {mq_q[Xlen-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          mq_d  = {mq_q[Xlen-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res_d  = '0;
    vld_d  = 1'b0;
    halt_d = 1'b0;
    uns_d  = 1'b0;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (op_q == OP_SPECIAL) begin
      case (fn_q)
        FN_SLL: begin res_d = b_q << sa_q; vld_d = 1'b1; end
        FN_SRL: begin res_d = b_q >> sa_q; vld_d = 1'b1; end
        FN_SRA: begin res_d = $unsigned($signed(b_q) >>> sa_q); vld_d = 1'b1; end
        FN_JR, FN_JALR: ;
        FN_SYSCALL: halt_d = (code_q == Xlen'(EXIT_CODE));
        FN_MFHI: begin res_d = hi_q; vld_d = 1'b1; end
        FN_MTHI: hi_d = a_q;
        FN_MFLO: begin res_d = lo_q; vld_d = 1'b1; end
        FN_MTLO: lo_d = a_q;
        FN_MULT, FN_MULTU: begin
          if (neg_q_q) begin
            hi_d = prod_neg[2*Xlen-1:Xlen];
            lo_d = prod_neg[Xlen-1:0];
          end else begin
            hi_d = acc_q;
            lo_d = mq_q;
          end
        end
        FN_DIV, FN_DIVU: begin
          if (!div0) begin
            lo_d = neg_q_q ? ('0 - mq_q) : mq_q;
            hi_d = neg_r_q ? ('0 - acc_q) : acc_q;
          end
        end
        FN_ADD, FN_ADDU: begin res_d = a_q + b_q; vld_d = 1'b1; end
        FN_SUB, FN_SUBU: begin res_d = a_q - b_q; vld_d = 1'b1; end
        FN_AND: begin res_d = a_q & b_q; vld_d = 1'b1; end
        FN_OR:  begin res_d = a_q | b_q; vld_d = 1'b1; end
        FN_XOR: begin res_d = a_q ^ b_q; vld_d = 1'b1; end
        FN_NOR: begin res_d = ~(a_q | b_q); vld_d = 1'b1; end
        FN_SLT: begin
          res_d = Xlen'($signed(a_q) < $signed(b_q));
          vld_d = 1'b1;
        end
        default: uns_d = 1'b1;
      endcase
    end else begin
      case (op_q)
        OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: ;
        OP_ADDI, OP_ADDIU, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: begin
          res_d = add_imm; vld_d = 1'b1;
        end
        OP_SLTI: begin
          res_d = Xlen'($signed(a_q) < $signed(sext_imm));
          vld_d = 1'b1;
        end
        OP_ANDI: begin res_d = a_q & zext_imm; vld_d = 1'b1; end
        OP_ORI:  begin res_d = a_q | zext_imm; vld_d = 1'b1; end
        OP_XORI: begin res_d = a_q ^ zext_imm; vld_d = 1'b1; end
        OP_LUI:  begin res_d = {imm_q, {(Xlen-16){1'b0}}}; vld_d = 1'b1; end
        default: uns_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q   <= mode_i;
      fn_q   <= function_code_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      imm_q  <= immediate_i;
      sa_q   <= shift_amount_i;
      code_q <= syscall_code_i;
    end
    acc_q   <= acc_d;
    mq_q    <= mq_d;
    dv_q    <= dv_d;
    cnt_q   <= cnt_d;
    neg_q_q <= neg_q_d;
    neg_r_q <= neg_r_d;
    if (ctl_i.finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= '0;
      lo_q   <= '0;
      vld_q  <= 1'b0;
      halt_q <= 1'b0;
      uns_q  <= 1'b0;
    end else if (ctl_i.finish) begin
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      vld_q  <= vld_d;
      halt_q <= halt_d;
      uns_q  <= uns_d;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = vld_q;
  assign hi_value_o     = hi_q;
  assign lo_value_o     = lo_q;
  assign halt_o         = halt_q;
  assign unsupported_o  = uns_q;
endmodule
`default_nettype wire

### rtl/risc_integer_execute_unit_core.sv
// Accept registers the operands; simple operations finish from PREP, while
//   MULT/MULTU and DIV/DIVU (nonzero divisor) run one bit per cycle, shared engine.
// Throughput: one instruction at a time; a new one is taken in the cycle its
//   predecessor's result is taken.
// Reset (rst_ni low, asynchronous): HI and LO cleared, controller idle.
`default_nettype none
module risc_integer_execute_unit_core #(
  parameter int unsigned Xlen = rieu_pkg::XLEN
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [5:0]      mode_i,
  input  wire logic [5:0]      function_code_i,
  input  wire logic [Xlen-1:0] operand_a_i,
  input  wire logic [Xlen-1:0] operand_b_i,
  input  wire logic [15:0]     immediate_i,
  input  wire logic [4:0]      shift_amount_i,
  input  wire logic [Xlen-1:0] syscall_code_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [Xlen-1:0]      result_o,
  output logic                 result_valid_o,
  output logic [Xlen-1:0]      hi_value_o,
  output logic [Xlen-1:0]      lo_value_o,
  output logic                 halt_o,
  output logic                 unsupported_o
);
  import rieu_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rieu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rieu_dpath #(.Xlen(Xlen)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .function_code_i (function_code_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .immediate_i     (immediate_i),
    .shift_amount_i  (shift_amount_i),
    .syscall_code_i  (syscall_code_i),
    .result_o        (result_o),
    .result_valid_o  (result_valid_o),
    .hi_value_o      (hi_value_o),
    .lo_value_o      (lo_value_o),
    .halt_o          (halt_o),
    .unsupported_o   (unsupported_o)
  );
endmodule
`default_nettype wire

### rtl/rieu_checker.sv
`default_nettype none
module rieu_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        result_valid_o,
  input wire logic        halt_o,
  input wire logic        unsupported_o,
  input wire logic [31:0] result_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown right after accept");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({result_valid_o, halt_o, unsupported_o}))
    else $error("conflicting result flags");

  a_unsup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |-> result_o == 32'd0)
    else $error("nonzero result without valid");
endmodule

bind risc_integer_execute_unit_core rieu_props u_rieu_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_valid_o (result_valid_o),
  .halt_o         (halt_o),
  .unsupported_o  (unsupported_o),
  .result_o       (result_o)
);
`default_nettype wire

### verif/rieu_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module rieu_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [5:0]  mode_i,
  input  wire logic [5:0]  function_code_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  input  wire logic [15:0] immediate_i,
  input  wire logic [4:0]  shift_amount_i,
  input  wire logic [31:0] syscall_code_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] result_i,
  input  wire logic        result_valid_i,
  input  wire logic [31:0] hi_value_i,
  input  wire logic [31:0] lo_value_i,
  input  wire logic        halt_i,
  input  wire logic        unsupported_i,
  output int unsigned      fail_cnt_o,
  output int unsigned      pending_o,
  output int unsigned      done_cnt_o
);
  import rieu_pkg::*;

  typedef struct packed {
    logic [31:0] res;
    logic        res_vld;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        halt;
    logic        unsup;
  } exec_res_t;

  exec_res_t   exp_q[$];
  logic [31:0] hi_q, lo_q;

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic predict_exec();
    exec_res_t   r;
    logic [31:0] a, b, ua, ub, q, m;
    logic [63:0] p;
    a = operand_a_i;
    b = operand_b_i;
    r = '0;
    if (mode_i == OP_SPECIAL) begin
      case (function_code_i)
        FN_SLL: begin r.res = b << shift_amount_i; r.res_vld = 1; end
        FN_SRL: begin r.res = b >> shift_amount_i; r.res_vld = 1; end
        FN_SRA: begin r.res = $signed(b) >>> shift_amount_i; r.res_vld = 1; end
        FN_JR, FN_JALR: ;
        FN_SYSCALL: r.halt = (syscall_code_i == EXIT_CODE);
        FN_MFHI: begin r.res = hi_q; r.res_vld = 1; end
        FN_MTHI: hi_q = a;
        FN_MFLO: begin r.res = lo_q; r.res_vld = 1; end
        FN_MTLO: lo_q = a;
        FN_MULT: begin
          p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          {hi_q, lo_q} = p;
        end
        FN_MULTU: begin
          p = {32'd0, a} * {32'd0, b};
          {hi_q, lo_q} = p;
        end
        FN_DIV: if (b != 0) begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub;
          m = ua % ub;
          lo_q = (a[31] != b[31]) ? -q : q;
          hi_q = a[31] ? -m : m;
        end
        FN_DIVU: if (b != 0) begin
          lo_q = a / b;
          hi_q = a % b;
        end
        FN_ADD, FN_ADDU: begin r.res = a + b; r.res_vld = 1; end
        FN_SUB, FN_SUBU: begin r.res = a - b; r.res_vld = 1; end
        FN_AND: begin r.res = a & b; r.res_vld = 1; end
        FN_OR:  begin r.res = a | b; r.res_vld = 1; end
        FN_XOR: begin r.res = a ^ b; r.res_vld = 1; end
        FN_NOR: begin r.res = ~(a | b); r.res_vld = 1; end
        FN_SLT: begin r.res = {31'd0, $signed(a) < $signed(b)}; r.res_vld = 1; end
        default: r.unsup = 1;
      endcase
    end else begin
      case (mode_i)
        OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: ;
        OP_ADDI, OP_ADDIU, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: begin
          r.res = a + sext(immediate_i); r.res_vld = 1;
        end
        OP_SLTI: begin
          r.res = {31'd0, $signed(a) < $signed(sext(immediate_i))}; r.res_vld = 1;
        end
        OP_ANDI: begin r.res = a & {16'd0, immediate_i}; r.res_vld = 1; end
        OP_ORI:  begin r.res = a | {16'd0, immediate_i}; r.res_vld = 1; end
        OP_XORI: begin r.res = a ^ {16'd0, immediate_i}; r.res_vld = 1; end
        OP_LUI:  begin r.res = {immediate_i, 16'd0}; r.res_vld = 1; end
        default: r.unsup = 1;
      endcase
    end
    r.hi = hi_q;
    r.lo = lo_q;
    exp_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    done_cnt_o = 0;
    hi_q = '0;
    lo_q = '0;
  end

  assign pending_o = exp_q.size();

  always @(posedge clk_i) begin
    exec_res_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        done_cnt_o++;
        if (exp_q.size() == 0) begin
          report_mismatch("unexpected transaction", result_i, '0);
        end else begin
          e = exp_q.pop_front();
          if (result_i !== e.res) report_mismatch("result", result_i, e.res);
          if (result_valid_i !== e.res_vld)
            report_mismatch("result_valid", result_valid_i, e.res_vld);
          if (hi_value_i !== e.hi) report_mismatch("hi", hi_value_i, e.hi);
          if (lo_value_i !== e.lo) report_mismatch("lo", lo_value_i, e.lo);
          if (halt_i !== e.halt) report_mismatch("halt", halt_i, e.halt);
          if (unsupported_i !== e.unsup)
            report_mismatch("unsupported", unsupported_i, e.unsup);
        end
      end
      if (in_valid_i && in_ready_i) predict_exec();
    end
  end
endmodule
`default_nettype wire

### verif/tb_risc_integer_execute_unit_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_risc_integer_execute_unit_core;
  import rieu_pkg::*;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  mode = '0;
  logic [5:0]  func = '0;
  logic [31:0] op_a = '0;
  logic [31:0] op_b = '0;
  logic [15:0] imm = '0;
  logic [4:0]  shamt = '0;
  logic [31:0] sys_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result, hi_value, lo_value;
  logic        result_valid, halt, unsupported;
  int unsigned fail_cnt, pending, done_cnt;
  int unsigned idle_cycles = 0;
  int unsigned sent_cnt = 0;
  logic        quiet_phase = 1'b0;
  logic        long_hold = 1'b0;
  logic        long_hold_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  risc_integer_execute_unit_core i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .function_code_i(func),
    .operand_a_i(op_a), .operand_b_i(op_b),
    .immediate_i(imm), .shift_amount_i(shamt),
    .syscall_code_i(sys_code),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_o(result), .result_valid_o(result_valid),
    .hi_value_o(hi_value), .lo_value_o(lo_value),
    .halt_o(halt), .unsupported_o(unsupported)
  );

  rieu_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .function_code_i(func),
    .operand_a_i(op_a), .operand_b_i(op_b),
    .immediate_i(imm), .shift_amount_i(shamt),
    .syscall_code_i(sys_code),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .result_i(result), .result_valid_i(result_valid),
    .hi_value_i(hi_value), .lo_value_i(lo_value),
    .halt_i(halt), .unsupported_i(unsupported),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .done_cnt_o(done_cnt)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired, %0d transactions outstanding", pending);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_instr(input logic [5:0] m, input logic [5:0] f,
                            input logic [31:0] a, input logic [31:0] b,
                            input logic [15:0] i, input logic [4:0] s,
                            input logic [31:0] c);
    mode <= m; func <= f; op_a <= a; op_b <= b;
    imm <= i; shamt <= s; sys_code <= c;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  localparam logic [5:0] FnList[23] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR,
    FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV,
    FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
    FN_SLT};
  localparam logic [5:0] OpList[21] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE,
    OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI,
    OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW, OP_SPECIAL};

  task automatic send_random();
    logic [5:0]  m, f;
    logic [31:0] b;
    int unsigned k;
    k = $urandom_range(0, 9);
    m = (k < 6) ? OP_SPECIAL : (k < 9) ? OpList[$urandom_range(0, 19)] : 6'($urandom);
    f = ($urandom_range(0, 9) == 0) ? 6'($urandom) : FnList[$urandom_range(0, 22)];
    b = pick_word();
    if ((f == FN_DIV || f == FN_DIVU) && $urandom_range(0, 3) != 0 && b == 0) b = 1;
    send_instr(m, f, pick_word(), b, 16'($urandom), 5'($urandom),
               ($urandom_range(0, 3) == 0) ? EXIT_CODE : pick_word());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed
    send_instr(OP_SPECIAL, FN_MFHI, '0, '0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_SLL, '0, 32'hFFFF_FFFF, '0, 5'd31, '0);
    send_instr(OP_SPECIAL, FN_SRA, '0, 32'h8000_0000, '0, 5'd31, '0);
    send_instr(OP_SPECIAL, FN_SRL, '0, 32'h8000_0000, '0, 5'd31, '0);
    send_instr(OP_SPECIAL, FN_SLT, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
    send_instr(OP_SLTI, '0, 32'h7FFF_FFFF, '0, 16'h8000, '0, '0);
    send_instr(OP_SPECIAL, FN_ADD, 32'h7FFF_FFFF, 32'h1, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_SUB, 32'h0, 32'h1, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MULT, 32'h8000_0000, 32'h8000_0000, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MFHI, '0, '0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_DIV, 32'hFFFF_FFF9, 32'h2, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_DIV, 32'h5, 32'h0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_DIVU, 32'hFFFF_FFFF, 32'h0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_DIVU, 32'hFFFF_FFFF, 32'h7, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MTHI, 32'hDEAD_BEEF, '0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MTLO, 32'h1234_5678, '0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_MFLO, '0, '0, '0, '0, '0);
    send_instr(OP_SPECIAL, FN_SYSCALL, '0, '0, '0, '0, EXIT_CODE);
    send_instr(OP_SPECIAL, FN_SYSCALL, '0, '0, '0, '0, 32'hB);
    send_instr(OP_LUI, '0, '0, '0, 16'hFFFF, '0, '0);
    send_instr(OP_LW, '0, 32'h0000_1000, '0, 16'hFFFC, '0, '0);
    send_instr(OP_BEQ, '0, '0, '0, '0, '0, '0);
    send_instr(6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31,
               32'hFFFF_FFFF);
    // random with a long receiver hold-off a third of the way in
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) long_hold = 1'b1;
      if (i == NumRandom / 2) drain();
      if (i == NumRandom - 150) quiet_phase = 1'b1;
      send_random();
    end
    drain();
    repeat (40) @(negedge clk_i);
    $display("sent %0d instructions, checked %0d results: all ops, edge operands,",
             sent_cnt, done_cnt);
    $display("HI/LO chains, divide by zero and overflow, halt, unknown codes, stalls");
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/rieu_pkg.sv
rtl/rieu_ctrl.sv
rtl/rieu_dpath.sv
rtl/risc_integer_execute_unit_core.sv
rtl/rieu_checker.sv
verif/rieu_checker.sv
verif/tb_risc_integer_execute_unit_core.sv
